>>> rtl/asyn_pkg.sv
`default_nettype none

package asyn_pkg;

    // Core dimensions.
    localparam int NUM_PARTIALS    = 8;
    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SAMPLE_BITS     = 16;

    // Fixed field widths of the ports.
    localparam int START_W     = 32;
    localparam int INC_W       = 32;
    localparam int AMP_W       = 16;
    localparam int WORD_W      = INC_W + AMP_W;
    localparam int CFG_INDEX_W = 3;
    localparam int MAG_W       = 15;
    localparam int PROD_W      = 32;
    localparam int TERM_W      = PROD_W - MAG_W;

    localparam int IN_TDATA_W  = ((START_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    // The running sum must hold every partial at full scale and the
    // saturation limits of the sample.
    localparam int SUM_W_RAW = TERM_W + $clog2(NUM_PARTIALS);
    localparam int SUM_W     = (SUM_W_RAW > SAMPLE_BITS + 1) ? SUM_W_RAW : SAMPLE_BITS + 1;

    localparam int QTR_N  = 2 ** SINE_TABLE_BITS;
    localparam int ADDR_W = SINE_TABLE_BITS + 1;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;

    typedef logic [PHASE_BITS-1:0] phase_t;
    typedef logic [MAG_W-1:0] qtr_table_t [0:QTR_N];

    // What travels from cell to cell along with one sample tick.
    typedef struct packed {
        logic                    restart;
        logic [START_W-1:0]      start_phase;
        logic                    last;
        logic signed [SUM_W-1:0] sum;
    } asyn_beat_t;

    // Zero-extends or masks a 32-bit phase value to the accumulator width.
    function automatic phase_t to_phase(input logic [START_W-1:0] value);
        logic [63:0] wide;
        wide = 64'(value);
        return wide[PHASE_BITS-1:0];
    endfunction

    // Unsigned floor quotient by restoring long division. Used while the
    // sine table is built at elaboration; the divisor stays small.
    function automatic longint unsigned div_floor(input longint unsigned num,
                                                  input longint unsigned den);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] n;
        q   = '0;
        rem = '0;
        n   = num;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], n[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Quarter-wave entry: 32767 * sin(pi/2 * k / QTR_N), from a Q30 Taylor
    // series, rounded half up. Evaluated at elaboration only.
    function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k);
        longint unsigned x;
        longint unsigned term;
        longint unsigned r;
        longint unsigned den;
        longint          s;
        x    = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
        term = x;
        s    = longint'(x);
        for (int n = 1; n <= 9; n++) begin
            den  = 64'((2 * n) * (2 * n + 1));
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = div_floor(term, den);
            if ((n % 2) == 1) begin
                s = s - longint'(term);
            end
            else begin
                s = s + longint'(term);
            end
        end
        if (s < 0) begin
            s = 0;
        end
        if (s > longint'(Q30_ONE)) begin
            s = longint'(Q30_ONE);
        end
        r = (64'(s) * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[MAG_W-1:0];
    endfunction

    function automatic qtr_table_t build_qtr_table();
        qtr_table_t t;
        for (int k = 0; k < QTR_N; k++) begin
            t[k] = sine_entry(k);
        end
        t[QTR_N] = MAG_W'(32767);
        return t;
    endfunction

    localparam qtr_table_t QTR_TABLE = build_qtr_table();

endpackage

`default_nettype wire

>>> rtl/asyn_cell.sv
`default_nettype none

// One oscillator of the bank: owns a phase accumulator and adds its scaled
// sine term to the running sum that passes through it. Three stages: table
// read, multiply, truncate and accumulate.
module asyn_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [asyn_pkg::WORD_W-1:0] word,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire asyn_pkg::asyn_beat_t      in_beat,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output asyn_pkg::asyn_beat_t           out_beat
);

    asyn_pkg::phase_t phase_reg;
    asyn_pkg::phase_t phase_cur;
    asyn_pkg::phase_t phase_next;
    asyn_pkg::phase_t phase_inc;

    logic [1:0]                          quad;
    logic [asyn_pkg::SINE_TABLE_BITS-1:0] offset;
    logic [asyn_pkg::ADDR_W-1:0]          addr;

    logic                                v1_reg, v2_reg, v3_reg;
    logic                                adv1, adv2, adv3;
    asyn_pkg::asyn_beat_t                b1_reg, b2_reg, b3_reg;
    logic [asyn_pkg::MAG_W-1:0]          mag1_reg;
    logic                                neg1_reg, neg2_reg;
    logic signed [asyn_pkg::PROD_W-1:0]  prod2_reg;

    logic signed [asyn_pkg::AMP_W-1:0]   amp;
    logic signed [asyn_pkg::AMP_W-1:0]   mag_s;
    logic signed [asyn_pkg::PROD_W-1:0]  prod;
    logic signed [asyn_pkg::PROD_W-1:0]  prod_signed;
    logic signed [asyn_pkg::PROD_W-1:0]  prod_biased;
    logic signed [asyn_pkg::TERM_W-1:0]  term;
    logic signed [asyn_pkg::SUM_W-1:0]   sum_next;

    // Stall chain: a stage moves when it is empty or its successor moves.
    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    // Phase used for this tick, then the mirrored quarter-wave address.
    assign phase_cur  = in_beat.restart ? asyn_pkg::to_phase(in_beat.start_phase) : phase_reg;
    assign phase_inc  = asyn_pkg::to_phase(word[asyn_pkg::INC_W-1:0]);
    assign phase_next = phase_cur + phase_inc;
    assign quad       = phase_cur[asyn_pkg::PHASE_BITS-1 -: 2];
    assign offset     = phase_cur[asyn_pkg::PHASE_BITS-3 -: asyn_pkg::SINE_TABLE_BITS];
    assign addr       = quad[0] ? asyn_pkg::ADDR_W'(asyn_pkg::QTR_N) - {1'b0, offset}
                                : {1'b0, offset};

    assign amp   = word[asyn_pkg::WORD_W-1 -: asyn_pkg::AMP_W];
    assign mag_s = {1'b0, mag1_reg};
    assign prod  = asyn_pkg::PROD_W'(amp) * asyn_pkg::PROD_W'(mag_s);

    // Truncation toward zero: negative values are biased before the shift.
    assign prod_signed = neg2_reg ? -prod2_reg : prod2_reg;
    assign prod_biased = prod_signed + (prod_signed[asyn_pkg::PROD_W-1]
                         ? asyn_pkg::PROD_W'(2 ** asyn_pkg::MAG_W - 1) : '0);
    assign term        = prod_biased[asyn_pkg::PROD_W-1 -: asyn_pkg::TERM_W];
    assign sum_next    = b2_reg.sum + {{(asyn_pkg::SUM_W - asyn_pkg::TERM_W){term[asyn_pkg::TERM_W-1]}},
                                       term};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end
        else begin
            if (adv1 && in_valid) begin
                phase_reg <= phase_next;
            end
            if (adv1) begin
                v1_reg <= in_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (adv1) begin
            b1_reg   <= in_beat;
            mag1_reg <= asyn_pkg::QTR_TABLE[addr];
            neg1_reg <= quad[1];
        end
        if (adv2) begin
            b2_reg    <= b1_reg;
            prod2_reg <= prod;
            neg2_reg  <= neg1_reg;
        end
        if (adv3) begin
            b3_reg <= '{restart:     b2_reg.restart,
                        start_phase: b2_reg.start_phase,
                        last:        b2_reg.last,
                        sum:         sum_next};
        end
    end

    assign out_valid = v3_reg;
    assign out_beat  = b3_reg;

endmodule

`default_nettype wire

>>> rtl/additive_sine_synthesizer_core.sv
`default_nettype none

// Additive sine synthesizer: a bank of asyn_pkg::NUM_PARTIALS phase-accumulator
// oscillators. Every input beat is one sample tick and yields exactly one
// output beat holding the saturated sum of amplitude times sine(phase) over
// all partials; m_axis_tuser flags a sample that was clipped to the 16-bit
// range, and tlast is passed through unchanged. A tick with restart set loads
// every phase with start_phase before its sample is formed; after each tick
// every phase advances by its increment. Partial i is configured by writing
// register index i: bits 31..0 hold the phase increment (f/fs * 2^32), bits
// 47..32 the signed amplitude; reset clears all words and phases, so the
// bank is silent until configured. Write configuration only while no beats
// are in flight. The partials form a chain of cells, each with a table read,
// a 16x16 multiply and an accumulate stage, followed by one saturation and
// output register: one beat is taken every clock cycle unless output
// back-pressure has stalled the chain up to the input. Back-pressure on
// the output stalls the chain one stage at a time, so empty stages keep
// filling while a finished sample waits.
module additive_sine_synthesizer_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_we,
    input  wire logic [asyn_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [asyn_pkg::WORD_W-1:0]       cfg_data,

    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [asyn_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // start_phase
    input  wire logic                              s_axis_tuser,   // restart
    input  wire logic                              s_axis_tlast,

    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [asyn_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,   // sample
    output logic                                   m_axis_tuser,   // clipped
    output logic                                   m_axis_tlast
);

    localparam int N = asyn_pkg::NUM_PARTIALS;

    localparam logic signed [asyn_pkg::SUM_W-1:0] SAT_MAX =
        asyn_pkg::SUM_W'(2 ** (asyn_pkg::SAMPLE_BITS - 1) - 1);
    localparam logic signed [asyn_pkg::SUM_W-1:0] SAT_MIN = -SAT_MAX - 1;

    logic [asyn_pkg::WORD_W-1:0] word_reg [0:N-1];

    logic                 valid_chain [0:N];
    logic                 ready_chain [0:N];
    asyn_pkg::asyn_beat_t beat_chain  [0:N];

    logic                               out_valid_reg;
    logic [asyn_pkg::SAMPLE_BITS-1:0]   sample_reg;
    logic                               clip_reg;
    logic                               last_reg;
    logic                               out_adv;
    logic signed [asyn_pkg::SUM_W-1:0]  final_sum;
    logic [asyn_pkg::SAMPLE_BITS-1:0]   sample_next;
    logic                               clip_next;

    // Configuration words, one per partial.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < N; i++) begin
                word_reg[i] <= '0;
            end
        end
        else if (cfg_we) begin
            for (int i = 0; i < N; i++) begin
                if (cfg_index == asyn_pkg::CFG_INDEX_W'(i)) begin
                    word_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Head of the chain: the running sum starts at zero.
    assign valid_chain[0]             = s_axis_tvalid;
    assign s_axis_tready              = ready_chain[0];
    assign beat_chain[0].restart      = s_axis_tuser;
    assign beat_chain[0].start_phase  = s_axis_tdata[asyn_pkg::START_W-1:0];
    assign beat_chain[0].last         = s_axis_tlast;
    assign beat_chain[0].sum          = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        asyn_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .word      (word_reg[g]),
            .in_valid  (valid_chain[g]),
            .in_ready  (ready_chain[g]),
            .in_beat   (beat_chain[g]),
            .out_valid (valid_chain[g+1]),
            .out_ready (ready_chain[g+1]),
            .out_beat  (beat_chain[g+1])
        );
    end

    // Saturation and output register.
    assign out_adv        = !out_valid_reg || m_axis_tready;
    assign ready_chain[N] = out_adv;
    assign final_sum      = beat_chain[N].sum;

    always_comb begin
        if (final_sum > SAT_MAX) begin
            sample_next = SAT_MAX[asyn_pkg::SAMPLE_BITS-1:0];
            clip_next   = 1'b1;
        end
        else if (final_sum < SAT_MIN) begin
            sample_next = SAT_MIN[asyn_pkg::SAMPLE_BITS-1:0];
            clip_next   = 1'b1;
        end
        else begin
            sample_next = final_sum[asyn_pkg::SAMPLE_BITS-1:0];
            clip_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv) begin
            out_valid_reg <= valid_chain[N];
        end
    end

    always_ff @(posedge clk) begin
        if (out_adv) begin
            sample_reg <= sample_next;
            clip_reg   <= clip_next;
            last_reg   <= beat_chain[N].last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = asyn_pkg::OUT_TDATA_W'(sample_reg);
    assign m_axis_tuser  = clip_reg;
    assign m_axis_tlast  = last_reg;

`ifndef SYNTHESIS
    // A clipped sample sits exactly at one of the two limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (sample_reg == SAT_MAX[asyn_pkg::SAMPLE_BITS-1:0] ||
             sample_reg == SAT_MIN[asyn_pkg::SAMPLE_BITS-1:0]))
        else $error("clipped sample is not at a saturation limit");

    // The input can only stall while a finished sample waits at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output back-pressure");

    // A sample in the output register that is not taken stays unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> (out_valid_reg && $stable(sample_reg)
                                               && $stable(clip_reg)))
        else $error("waiting sample changed");
`endif

endmodule

`default_nettype wire
